### rtl/line_sensor_ternary_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled under rst.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_TERNARY_ENCODER_CORE_DEFINES_SVH
`define LINE_SENSOR_TERNARY_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LSTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lste: same-cycle check failed");

// Next-cycle implication.
`define LSTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lste: next-cycle check failed");

`endif

### rtl/lste_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - package
// Types, constants and shared arithmetic helpers for the encoder core.
// ----------------------------------------------------------------------------
package lste_pkg;

  localparam int CHANNELS    = 5;
  localparam int SAMPLE_BITS = 12;
  localparam int SPAN_BITS   = SAMPLE_BITS + 1;
  localparam int PCT_BITS    = 7;
  localparam int PROD_BITS   = SPAN_BITS + PCT_BITS;
  localparam int CODE_BITS   = 8;
  localparam int LEVEL_BITS  = 2;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [PCT_BITS-1:0]    PCT_FULL       = PCT_BITS'(100);
  localparam logic [PCT_BITS-1:0]    EDGE_PCT_RST   = PCT_BITS'(14);
  localparam logic [PCT_BITS-1:0]    LINE_PCT_RST   = PCT_BITS'(50);
  localparam logic [PCT_BITS-1:0]    DARK_PCT_RST   = PCT_BITS'(10);
  localparam logic [SAMPLE_BITS-1:0] MIN_SPAN_RST   = SAMPLE_BITS'(200);
  localparam logic [CODE_BITS-1:0]   CODE_MAX       = CODE_BITS'(242);

  localparam logic [LEVEL_BITS-1:0] LVL_OFF  = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_EDGE = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_LINE = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_END      = 2'd2,
    OP_CLASSIFY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_EDGE_PCT = 2'd0,
    REG_LINE_PCT = 2'd1,
    REG_DARK_PCT = 2'd2,
    REG_MIN_SPAN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
  } lste_frame_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] state_code;
    logic                 all_dark;
  } lste_code_t;

  typedef struct packed {
    logic [PCT_BITS-1:0]    edge_pct;
    logic [PCT_BITS-1:0]    line_pct;
    logic [PCT_BITS-1:0]    dark_pct;
    logic [SAMPLE_BITS-1:0] min_span;
  } lste_cfg_t;

  typedef struct packed {
    logic    en;
    opcode_t op;
  } lste_cal_cmd_t;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lste_samples_t;
  typedef logic [CHANNELS-1:0][SPAN_BITS-1:0]   lste_bright_t;
  typedef logic [CHANNELS-1:0][LEVEL_BITS-1:0]  lste_levels_t;

  // d*100 < pct*span, exact
  function automatic logic below_pct(logic [SPAN_BITS-1:0] d,
                                     logic [SPAN_BITS-1:0] span,
                                     logic [PCT_BITS-1:0]  pct);
    logic [PROD_BITS-1:0] lhs;
    logic [PROD_BITS-1:0] rhs;
    lhs = PROD_BITS'(d) * PROD_BITS'(PCT_FULL);
    rhs = PROD_BITS'(pct) * PROD_BITS'(span);
    return lhs < rhs;
  endfunction

  // Base-3 pack, channel 0 most significant
  function automatic logic [CODE_BITS-1:0] pack_levels(lste_levels_t lvl);
    logic [CODE_BITS-1:0] code;
    code = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      code = CODE_BITS'({code, 1'b0}) + code + CODE_BITS'(lvl[i]);
    end
    return code;
  endfunction

endpackage

### rtl/line_sensor_ternary_encoder_core.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder core
// Five-channel min/max calibrated reflectance grader with base-3 state code.
// ----------------------------------------------------------------------------
// Takes one frame transfer per clock unless stalled and, for every classify
// frame, returns a code transfer through the execute stage and the code
// register; clear, sample and end-of-calibration frames update the per-channel
// dark/bright store with a read-modify-write in the execute stage and return
// nothing. Throughput is one frame per cycle but for stalls: a stalled code
// output holds the execute stage only while it carries a classify frame.
// Thresholds are exact integer percentages (d*100 < pct*span); registers sit
// at byte addresses 0 (edge_pct), 4 (line_pct), 8 (dark_pct) and 12 (min_span),
// and are to be written by the user only while no frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "line_sensor_ternary_encoder_core_defines.svh"

module line_sensor_ternary_encoder_core
  import lste_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // frame input
  input  logic                 frame_valid,
  output logic                 frame_stall,
  input  lste_frame_t          frame,
  // code output
  output logic                 code_valid,
  input  logic                 code_stall,
  output lste_code_t           code,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  lste_cfg_t     cfg;
  logic          s1_valid;
  lste_frame_t   s1_item;
  logic          s1_go;
  logic          s1_classify;
  logic          code_free;
  logic          frame_take;
  lste_samples_t s1_samples;
  lste_samples_t dark;
  lste_bright_t  bright;
  lste_levels_t  levels;
  logic [CHANNELS-1:0] dark_flags;
  lste_cal_cmd_t cal_cmd;
  lste_code_t    result;

  lste_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Execute stage advances unless it holds a classify frame and the code
  // register is full and stalled.
  assign code_free   = !code_valid || !code_stall;
  assign s1_classify = (s1_item.opcode == OP_CLASSIFY);
  assign s1_go       = s1_valid && (!s1_classify || code_free);
  assign frame_stall = s1_valid && !s1_go;
  assign frame_take  = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Frame payload; no reset needed.
  always_ff @(posedge clk) begin
    if (frame_take) begin
      s1_item <= frame;
    end
  end

  assign s1_samples[0] = s1_item.sample_0;
  assign s1_samples[1] = s1_item.sample_1;
  assign s1_samples[2] = s1_item.sample_2;
  assign s1_samples[3] = s1_item.sample_3;
  assign s1_samples[4] = s1_item.sample_4;

  // Calibration store commits when the execute stage retires a non-classify frame.
  assign cal_cmd.en = s1_go && !s1_classify;
  assign cal_cmd.op = s1_item.opcode;

  lste_cal u_cal (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cal_cmd),
    .samples  (s1_samples),
    .min_span (cfg.min_span),
    .dark     (dark),
    .bright   (bright)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    lste_chan u_chan (
      .sample  (s1_samples[g]),
      .dark    (dark[g]),
      .bright  (bright[g]),
      .cfg     (cfg),
      .level   (levels[g]),
      .is_dark (dark_flags[g])
    );
  end

  assign result.state_code = pack_levels(levels);
  assign result.all_dark   = &dark_flags;

  // Code register: load on a retiring classify frame, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (s1_go && s1_classify) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_classify) begin
      code <= result;
    end
  end

  // A new code only ever comes from a classify frame in the execute stage.
  `LSTE_ASSERT_NOW(a_code_from_classify, $rose(code_valid),
                   $past(s1_valid) && $past(s1_item.opcode) == OP_CLASSIFY)
  // Input stalls only while the execute stage is occupied.
  `LSTE_ASSERT_NOW(a_stall_needs_item, frame_stall, s1_valid)
  // Packed code stays within five base-3 digits.
  `LSTE_ASSERT_NOW(a_code_range, code_valid, code.state_code <= CODE_MAX)
  // A blocked classify frame holds in the execute stage.
  `LSTE_ASSERT_NEXT(a_classify_holds,
                    s1_valid && s1_classify && code_valid && code_stall,
                    s1_valid && $stable(s1_item))

endmodule

### rtl/lste_regs.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - register file
// Threshold and span registers behind a simple APB slave.
// ----------------------------------------------------------------------------
module lste_regs
  import lste_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output lste_cfg_t            cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_pct <= EDGE_PCT_RST;
      cfg.line_pct <= LINE_PCT_RST;
      cfg.dark_pct <= DARK_PCT_RST;
      cfg.min_span <= MIN_SPAN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_EDGE_PCT: cfg.edge_pct <= pwdata[PCT_BITS-1:0];
        REG_LINE_PCT: cfg.line_pct <= pwdata[PCT_BITS-1:0];
        REG_DARK_PCT: cfg.dark_pct <= pwdata[PCT_BITS-1:0];
        REG_MIN_SPAN: cfg.min_span <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EDGE_PCT: prdata = DATA_BITS'(cfg.edge_pct);
      REG_LINE_PCT: prdata = DATA_BITS'(cfg.line_pct);
      REG_DARK_PCT: prdata = DATA_BITS'(cfg.dark_pct);
      REG_MIN_SPAN: prdata = DATA_BITS'(cfg.min_span);
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/lste_cal.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - calibration store
// Per-channel dark (min) and bright (max) levels with clear and span floor.
// ----------------------------------------------------------------------------
module lste_cal
  import lste_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lste_cal_cmd_t          cmd,
  input  lste_samples_t          samples,
  input  logic [SAMPLE_BITS-1:0] min_span,
  output lste_samples_t          dark,
  output lste_bright_t           bright
);

  lste_samples_t dark_next;
  lste_bright_t  bright_next;

  always_comb begin
    logic signed [SPAN_BITS:0] gap;
    dark_next   = dark;
    bright_next = bright;
    for (int i = 0; i < CHANNELS; i++) begin
      gap = $signed({1'b0, bright[i]}) - $signed({2'b0, dark[i]});
      case (cmd.op)
        OP_CLEAR: begin
          dark_next[i]   = '1;
          bright_next[i] = '0;
        end
        OP_SAMPLE: begin
          if (samples[i] < dark[i]) begin
            dark_next[i] = samples[i];
          end
          if ({1'b0, samples[i]} > bright[i]) begin
            bright_next[i] = {1'b0, samples[i]};
          end
        end
        OP_END: begin
          // raise bright so the span is at least min_span
          if (gap < $signed({2'b0, min_span})) begin
            bright_next[i] = {1'b0, dark[i]} + {1'b0, min_span};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dark[i]   <= '1;
        bright[i] <= '0;
      end
    end else if (cmd.en) begin
      dark   <= dark_next;
      bright <= bright_next;
    end
  end

endmodule

### rtl/lste_chan.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - channel classifier
// Clamps one sample into the calibrated span and grades it against thresholds.
// ----------------------------------------------------------------------------
module lste_chan
  import lste_pkg::*;
(
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] dark,
  input  logic [SPAN_BITS-1:0]   bright,
  input  lste_cfg_t              cfg,
  output logic [LEVEL_BITS-1:0]  level,
  output logic                   is_dark
);

  logic signed [SPAN_BITS:0] sp;
  logic [SPAN_BITS-1:0]      span;
  logic [SPAN_BITS-1:0]      d_raw;
  logic [SPAN_BITS-1:0]      d;

  // span floors at one, also when bright sits below dark
  assign sp    = $signed({1'b0, bright}) - $signed({2'b0, dark});
  assign span  = (sp < $signed((SPAN_BITS+1)'(1))) ? SPAN_BITS'(1) : sp[SPAN_BITS-1:0];
  assign d_raw = (sample > dark) ? {1'b0, sample - dark} : '0;
  assign d     = (d_raw > span) ? span : d_raw;

  always_comb begin
    if (below_pct(d, span, cfg.edge_pct)) begin
      level = LVL_OFF;
    end else if (below_pct(d, span, cfg.line_pct)) begin
      level = LVL_EDGE;
    end else begin
      level = LVL_LINE;
    end
  end

  assign is_dark = below_pct(d, span, cfg.dark_pct);

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Line sensor ternary encoder - self-checking testbench
// Drives calibration and classify frames through the core under changing
// thresholds and random handshake pressure, predicts every state code with an
// in-bench model of the calibration store, and checks the code transfers.
// ----------------------------------------------------------------------------
module tb_top;
  import lste_pkg::*;

  localparam int SETTLE_CYCLES  = 8;     // covers the two-stage pipeline with margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer of any kind
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES          = 8;

  // How a random sample is drawn.
  typedef enum logic [1:0] {
    PICK_ANY,   // full range, extremes favored
    PICK_CAL,   // dark or bright calibration target
    PICK_NEAR   // around the calibrated window of the channel
  } pick_t;

  // One row of the directed stimulus table.
  typedef struct {
    lste_frame_t frm;
    bit          typed;
    lste_code_t  want;
  } frame_row_t;

  logic                 clk;
  logic                 rst;
  logic                 frame_valid;
  logic                 frame_stall;
  lste_frame_t          frame;
  logic                 code_valid;
  logic                 code_stall;
  lste_code_t           code;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  line_sensor_ternary_encoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code        (code),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow of the thresholds and of the per-channel calibration store.
  lste_cfg_t              thresholds;
  logic [SAMPLE_BITS-1:0] cal_dark   [CHANNELS];
  logic [SPAN_BITS-1:0]   cal_bright [CHANNELS];

  lste_code_t codes_due[$];    // expected code transfers, oldest first
  frame_row_t directed_rows[$];
  int         error_count;
  int         quiet_cycles;
  int         idle_pct;        // sender gap probability, percent
  int         stall_pct;       // receiver stall probability, percent

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted frame to the shadow store. Only classify
  // frames produce a code; the thresholds are exact percentages, d*100 < p*span.
  // --------------------------------------------------------------------------
  function automatic bit under_pct(int d, int span, logic [PCT_BITS-1:0] pct);
    return d * 100 < int'(pct) * span;
  endfunction

  task automatic grade_frame(input lste_frame_t f, output bit makes_code,
                             output lste_code_t c);
    logic [SAMPLE_BITS-1:0] s [CHANNELS];
    int                     span;
    int                     d;
    int                     lvl;
    int                     acc;
    bit                     dark_all;
    s[0] = f.sample_0;
    s[1] = f.sample_1;
    s[2] = f.sample_2;
    s[3] = f.sample_3;
    s[4] = f.sample_4;
    makes_code = 1'b0;
    c = '0;
    case (f.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < CHANNELS; i++) begin
          cal_dark[i]   = '1;
          cal_bright[i] = '0;
        end
      end
      OP_SAMPLE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (s[i] < cal_dark[i]) cal_dark[i] = s[i];
          if (SPAN_BITS'(s[i]) > cal_bright[i]) cal_bright[i] = SPAN_BITS'(s[i]);
        end
      end
      OP_END: begin
        // widen any channel whose span falls short of min_span (signed compare)
        for (int i = 0; i < CHANNELS; i++) begin
          if (int'(cal_bright[i]) - int'(cal_dark[i]) < int'(thresholds.min_span))
            cal_bright[i] = SPAN_BITS'(cal_dark[i]) + SPAN_BITS'(thresholds.min_span);
        end
      end
      OP_CLASSIFY: begin
        acc = 0;
        dark_all = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          span = int'(cal_bright[i]) - int'(cal_dark[i]);
          if (span < 1) span = 1;
          d = (s[i] > cal_dark[i]) ? int'(s[i]) - int'(cal_dark[i]) : 0;
          if (d > span) d = span;
          if (under_pct(d, span, thresholds.edge_pct)) lvl = int'(LVL_OFF);
          else if (under_pct(d, span, thresholds.line_pct)) lvl = int'(LVL_EDGE);
          else lvl = int'(LVL_LINE);
          acc = acc * 3 + lvl;
          if (!under_pct(d, span, thresholds.dark_pct)) dark_all = 1'b0;
        end
        makes_code   = 1'b1;
        c.state_code = CODE_BITS'(acc);
        c.all_dark   = dark_all;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Frame side: optional gap, then hold valid and payload until the transfer.
  // --------------------------------------------------------------------------
  task automatic send_frame(lste_frame_t f, bit typed = 1'b0, lste_code_t want = '0);
    bit         makes_code;
    lste_code_t c;
    while ($urandom_range(99) < idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    grade_frame(f, makes_code, c);
    if (makes_code) codes_due.push_back(typed ? want : c);
  endtask

  // Drop valid and wait until the pipeline has drained.
  task automatic settle();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (codes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port: write, then read back. Dropping psel across a clock edge
  // between transfers keeps it from being lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_EDGE_PCT: thresholds.edge_pct = value[PCT_BITS-1:0];
      REG_LINE_PCT: thresholds.line_pct = value[PCT_BITS-1:0];
      REG_DARK_PCT: thresholds.dark_pct = value[PCT_BITS-1:0];
      REG_MIN_SPAN: thresholds.min_span = value[SAMPLE_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    // read back through the same port
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_EDGE_PCT: held = DATA_BITS'(thresholds.edge_pct);
      REG_LINE_PCT: held = DATA_BITS'(thresholds.line_pct);
      REG_DARK_PCT: held = DATA_BITS'(thresholds.dark_pct);
      default:      held = DATA_BITS'(thresholds.min_span);
    endcase
    if (prdata !== held) report_mismatch("register read", int'(prdata), int'(held));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Load all four thresholds; junk fills the unused upper bits of pwdata.
  task automatic load_thresholds(int e, int l, int dk, int ms, bit junk);
    logic [DATA_BITS-1:0] fill;
    fill = junk ? DATA_BITS'($urandom) : '0;
    write_reg(REG_EDGE_PCT, {fill[DATA_BITS-1:PCT_BITS], PCT_BITS'(e)});
    write_reg(REG_LINE_PCT, {fill[DATA_BITS-1:PCT_BITS], PCT_BITS'(l)});
    write_reg(REG_DARK_PCT, {fill[DATA_BITS-1:PCT_BITS], PCT_BITS'(dk)});
    write_reg(REG_MIN_SPAN, {fill[DATA_BITS-1:SAMPLE_BITS], SAMPLE_BITS'(ms)});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(pick_t how, int ch);
    int r;
    int lo;
    int hi;
    r = $urandom_range(9);
    case (how)
      PICK_CAL: begin
        if (r < 4) return SAMPLE_BITS'($urandom_range(1200, 0));
        if (r < 8) return SAMPLE_BITS'($urandom_range(4095, 2800));
      end
      PICK_NEAR: begin
        // land around dark..bright so every level and the all_dark flag get hit
        lo = int'(cal_dark[ch]) - 100;
        hi = int'(cal_bright[ch]) + 100;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if (r < 8 && hi >= lo) return SAMPLE_BITS'($urandom_range(hi, lo));
      end
      default: ;
    endcase
    if (r == 8) return '0;
    if (r == 9) return '1;
    return SAMPLE_BITS'($urandom_range(4095, 0));
  endfunction

  function automatic lste_frame_t build_frame(opcode_t op, pick_t how);
    lste_frame_t f;
    f.opcode   = op;
    f.sample_0 = pick_sample(how, 0);
    f.sample_1 = pick_sample(how, 1);
    f.sample_2 = pick_sample(how, 2);
    f.sample_3 = pick_sample(how, 3);
    f.sample_4 = pick_sample(how, 4);
    return f;
  endfunction

  task automatic add_row(opcode_t op, int s0, int s1, int s2, int s3, int s4,
                         bit typed = 1'b0, int want_code = 0, bit want_dark = 1'b0);
    frame_row_t row;
    row.frm.opcode      = op;
    row.frm.sample_0    = SAMPLE_BITS'(s0);
    row.frm.sample_1    = SAMPLE_BITS'(s1);
    row.frm.sample_2    = SAMPLE_BITS'(s2);
    row.frm.sample_3    = SAMPLE_BITS'(s3);
    row.frm.sample_4    = SAMPLE_BITS'(s4);
    row.typed           = typed;
    row.want.state_code = CODE_BITS'(want_code);
    row.want.all_dark   = want_dark;
    directed_rows.push_back(row);
  endtask

  // Mostly well-formed calibrate-then-classify runs with random content,
  // mixed with frames of random opcode.
  task automatic random_frames(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(4) != 0) begin
          send_frame(build_frame(OP_CLEAR, PICK_ANY));
          sent++;
        end
        repeat ($urandom_range(6, 1)) begin
          send_frame(build_frame(OP_SAMPLE, PICK_CAL));
          sent++;
        end
        if ($urandom_range(4) != 0) begin
          send_frame(build_frame(OP_END, PICK_ANY));
          sent++;
        end
        repeat ($urandom_range(10, 2)) begin
          send_frame(build_frame(OP_CLASSIFY, PICK_NEAR));
          sent++;
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_frame(build_frame(opcode_t'($urandom_range(3)), PICK_ANY));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Code side: random stall, and check each transfer against the oldest
  // expectation. Stall is driven by nonblocking assignment, so the value
  // read here is the one the core saw at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lste_code_t due;
    if (rst) begin
      code_stall <= 1'b0;
    end else begin
      code_stall <= ($urandom_range(99) < stall_pct);
      if (code_valid && !code_stall) begin
        if (codes_due.size() == 0) begin
          report_mismatch("unexpected code transfer, state_code", int'(code.state_code), -1);
        end else begin
          due = codes_due.pop_front();
          if (code.state_code !== due.state_code)
            report_mismatch("state_code", int'(code.state_code), int'(due.state_code));
          if (code.all_dark !== due.all_dark)
            report_mismatch("all_dark", int'(code.all_dark), int'(due.all_dark));
        end
      end
    end
  end

  // Watchdog: advance while nothing moves on any port, end the run at the limit.
  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (code_valid && !code_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("line_sensor_ternary_encoder_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    frame_valid  <= 1'b0;
    frame        <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    error_count  = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    thresholds.edge_pct = EDGE_PCT_RST;
    thresholds.line_pct = LINE_PCT_RST;
    thresholds.dark_pct = DARK_PCT_RST;
    thresholds.min_span = MIN_SPAN_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      cal_dark[i]   = '1;
      cal_bright[i] = '0;
    end

    // Directed table, reset thresholds. Uncalibrated store: span floors at 1
    // and no sample exceeds dark, so every channel is off line and dark.
    add_row(OP_CLASSIFY, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(OP_CLASSIFY, 4095, 4095, 4095, 4095, 4095, 1'b1, 0, 1'b1);
    // end of calibration with an empty store: bright = all ones + min_span
    add_row(OP_END, 0, 0, 0, 0, 0);
    add_row(OP_CLASSIFY, 4095, 4095, 4095, 4095, 4095, 1'b1, 0, 1'b1);
    // full-range calibration, then both extremes
    add_row(OP_CLEAR, 4095, 4095, 4095, 4095, 4095);
    add_row(OP_SAMPLE, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 4095, 4095, 4095, 4095, 4095);
    add_row(OP_CLASSIFY, 4095, 4095, 4095, 4095, 4095, 1'b1, int'(CODE_MAX), 1'b0);
    add_row(OP_CLASSIFY, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    // samples straddling the edge, line and dark thresholds by one count
    add_row(OP_CLASSIFY, 573, 574, 2047, 2048, 409);
    add_row(OP_END, 1, 2, 3, 4, 5);
    add_row(OP_CLASSIFY, 2048, 0, 4095, 0, 2048);
    // narrow spans widened by end of calibration, samples outside the window
    add_row(OP_CLEAR, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 1000, 1000, 1000, 1000, 1000);
    add_row(OP_SAMPLE, 3000, 1000, 3000, 1000, 3000);
    add_row(OP_END, 0, 0, 0, 0, 0);
    add_row(OP_CLASSIFY, 999, 1100, 3000, 1300, 4095);
    // single calibration sample: zero span floored to 1
    add_row(OP_CLEAR, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 2000, 0, 4095, 123, 3500);
    add_row(OP_CLASSIFY, 1999, 0, 4095, 124, 3499);
    add_row(OP_END, 0, 0, 0, 0, 0);
    add_row(OP_CLASSIFY, 2100, 100, 4095, 223, 3600);
    add_row(OP_SAMPLE, 4095, 4095, 0, 0, 2000);
    add_row(OP_CLASSIFY, 1000, 2000, 3000, 4000, 2345);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_frame(directed_rows[r].frm, directed_rows[r].typed, directed_rows[r].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: load_thresholds(0, 0, 0, 0, 1'b0);
          2: load_thresholds(127, 127, 127, 4095, 1'b0);  // percents above 100
          3: load_thresholds(100, 100, 100, 1, 1'b1);
          default: load_thresholds($urandom_range(60), $urandom_range(100, 40),
                                   $urandom_range(40), $urandom_range(4095), 1'b1);
        endcase
      end
      // rotate through the handshake pressure modes
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      random_frames(ITEMS_PER_PHASE);
    end

    settle();
    if (error_count == 0) begin
      $display("line_sensor_ternary_encoder_core test passed");
    end else begin
      $display("line_sensor_ternary_encoder_core test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lste_pkg.sv
rtl/lste_regs.sv
rtl/lste_cal.sv
rtl/lste_chan.sv
rtl/line_sensor_ternary_encoder_core.sv
tb/sv/tb_top.sv
